/* rtl/c8x_pkg.sv */
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared constants for the CHIP-8 execute block.
// ----------------------------------------------------------------------------
package c8x_pkg;
   localparam int MEM_DEPTH_DEF   = 4096;
   localparam int STACK_DEPTH_DEF = 16;
   localparam int REG_COUNT_DEF   = 16;
   localparam int START_ADDR_DEF  = 512;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNKNOWN   = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_UNDERFLOW = 2'd3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EXEC = 1'b1;

   localparam logic [15:0] W_CLS = 16'h00E0;
   localparam logic [15:0] W_RET = 16'h00EE;
endpackage

/* rtl/c8x_ram.sv */
// ----------------------------------------------------------------------------
// c8x_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module c8x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* rtl/chip8_instruction_execute.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// CHIP-8 execute unit: program memory, V registers, index, return stack.
// ----------------------------------------------------------------------------
// channel | dir | fields
// req     | in  | tdata: opcode, address, data_byte, random_byte
// rsp     | out | tdata: next_pc, index_value, status, clear_screen, flag,
//         |     |        delay, sound
// A program byte load writes memory and then responds; an instruction fetches
// two bytes, reads Vx and Vy, executes and responds, with the flag write after
// the result for 8xy4..8xyE, digit steps and three writes for Fx33, and for
// the block store/load one program memory access per register V0..Vx.
// The register file is reset-cleared by a full pass before req_tready rises.
// One item is in work at a time; a held result stalls the next item.
// ----------------------------------------------------------------------------
module chip8_instruction_execute
   import c8x_pkg::*;
#(
   parameter int MEM_DEPTH   = MEM_DEPTH_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int REG_COUNT   = REG_COUNT_DEF,
   parameter int START_ADDR  = START_ADDR_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode, address[12], data_byte[8], random_byte[8], pad
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_pc[12], index_value[16], status[2], clear_screen, flag_value[8],
   // delay_value[8], sound_value[8], pad
   output logic [55:0] rsp_tdata
);
   localparam int MAW = $clog2(MEM_DEPTH);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int RAW = $clog2(REG_COUNT);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   localparam logic [3:0] S_CLR  = 4'd0,  S_IDLE = 4'd1,  S_F0 = 4'd2,
                          S_F1   = 4'd3,  S_F2   = 4'd4,  S_RD = 4'd5,
                          S_EX   = 4'd6,  S_RET  = 4'd7,  S_BCD = 4'd8,
                          S_BLK  = 4'd9,  S_BLKW = 4'd10, S_OUT = 4'd11,
                          S_WB   = 4'd12, S_FIN = 4'd13;

   logic [3:0]  state_ff, state_in;
   logic [11:0] pc_ff, pc_in;
   logic [15:0] idx_ff, idx_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [7:0]  vf_ff, vf_in, dly_ff, dly_in, snd_ff, snd_in;
   logic [1:0]  st_ff, st_in;
   logic        clr_ff, clr_in;
   logic [15:0] w_ff, w_in;
   logic [7:0]  vx_ff, vx_in, rnd_ff, rnd_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [7:0]  bcd_ff [3];
   logic [7:0]  bcd_in [3];

   // memory ports
   logic           m_we;  logic [MAW-1:0] m_a; logic [7:0] m_wd, m_rd;
   logic           r_we;  logic [RAW-1:0] r_a; logic [7:0] r_wd, r_rd;
   logic           k_we;  logic [SAW-1:0] k_a; logic [11:0] k_wd, k_rd;

   c8x_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
      .clock(clock), .wr_en(m_we), .addr(m_a), .wr_data(m_wd), .rd_data(m_rd));
   c8x_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_regs (
      .clock(clock), .wr_en(r_we), .addr(r_a), .wr_data(r_wd), .rd_data(r_rd));
   c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(k_we), .addr(k_a), .wr_data(k_wd), .rd_data(k_rd));

   logic [3:0] xs, ys, ns, hi;
   logic [7:0] kk;
   logic [11:0] nnn;
   assign hi = w_ff[15:12]; assign xs = w_ff[11:8]; assign ys = w_ff[7:4];
   assign ns = w_ff[3:0];   assign kk = w_ff[7:0];  assign nnn = w_ff[11:0];

   logic [8:0] sum9, dxy, dyx;
   logic [15:0] bi;
   always_comb begin
      sum9 = {1'b0, vx_ff} + {1'b0, r_rd};
      dxy  = {1'b0, vx_ff} - {1'b0, r_rd};
      dyx  = {1'b0, r_rd} - {1'b0, vx_ff};
      bi   = idx_ff + {11'd0, cnt_ff};
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {1'b0, snd_ff, dly_ff, vf_ff, clr_ff, st_ff, idx_ff, pc_ff};

   always_comb begin
      state_in = state_ff; pc_in = pc_ff; idx_in = idx_ff; sp_in = sp_ff;
      vf_in = vf_ff; dly_in = dly_ff; snd_in = snd_ff; st_in = st_ff;
      clr_in = clr_ff; w_in = w_ff; vx_in = vx_ff; rnd_in = rnd_ff;
      cnt_in = cnt_ff; bcd_in = bcd_ff;
      m_we = 1'b0; m_a = pc_ff[MAW-1:0]; m_wd = 8'd0;
      r_we = 1'b0; r_a = xs; r_wd = 8'd0;
      k_we = 1'b0; k_a = sp_ff[SAW-1:0]; k_wd = pc_ff;
      case (state_ff)
         S_CLR: begin
            r_we = 1'b1; r_a = cnt_ff[RAW-1:0];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(REG_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            st_in = ST_OK; clr_in = 1'b0; rnd_in = req_tdata[28:21];
            if (req_tvalid) begin
               if (req_tdata[0] == OP_LOAD) begin
                  m_we = 1'b1; m_a = req_tdata[MAW:1]; m_wd = req_tdata[20:13];
                  state_in = S_OUT;
               end else begin
                  m_a = pc_ff[MAW-1:0]; state_in = S_F0;
               end
            end
         end
         S_F0: begin
            m_a = MAW'(pc_ff + 12'd1); w_in[15:8] = m_rd; state_in = S_F1;
         end
         S_F1: begin
            w_in[7:0] = m_rd; r_a = w_ff[11:8]; state_in = S_F2;
         end
         S_F2: begin
            // Vx now on r_rd; read Vy (or V0 for Bnnn)
            vx_in = r_rd; r_a = (hi == 4'hB) ? 4'd0 : ys;
            pc_in = pc_ff + 12'd2; state_in = S_EX;
            if (hi == 4'h0 && w_ff == W_RET && sp_ff != '0)
               k_a = SAW'(sp_ff - SPW'(1));
         end
         S_EX: begin
            state_in = S_OUT;
            r_a = xs;
            case (hi)
               4'h0: begin
                  if (w_ff == W_CLS) clr_in = 1'b1;
                  else if (w_ff == W_RET) begin
                     if (sp_ff == '0) st_in = ST_UNDERFLOW;
                     else begin
                        sp_in = sp_ff - SPW'(1); pc_in = k_rd;
                     end
                  end else st_in = ST_UNKNOWN;
               end
               4'h1: pc_in = nnn;
               4'h2: begin
                  if (sp_ff >= SPW'(STACK_DEPTH)) st_in = ST_OVERFLOW;
                  else begin
                     k_we = 1'b1; k_wd = pc_ff; sp_in = sp_ff + SPW'(1); pc_in = nnn;
                  end
               end
               4'h3: if (vx_ff == kk) pc_in = pc_ff + 12'd2;
               4'h4: if (vx_ff != kk) pc_in = pc_ff + 12'd2;
               4'h5, 4'h9: begin
                  if (ns != 4'd0) st_in = ST_UNKNOWN;
                  else if ((vx_ff == r_rd) == (hi == 4'h5)) pc_in = pc_ff + 12'd2;
               end
               4'h6: begin
                  r_we = 1'b1; r_wd = kk;
                  if (xs == 4'hF) vf_in = r_wd;
               end
               4'h7: begin
                  r_we = 1'b1; r_wd = vx_ff + kk;
                  if (xs == 4'hF) vf_in = r_wd;
               end
               4'h8: begin
                  r_we = 1'b1;
                  case (ns)
                     4'h0: r_wd = r_rd;
                     4'h1: r_wd = vx_ff | r_rd;
                     4'h2: r_wd = vx_ff & r_rd;
                     4'h3: r_wd = vx_ff ^ r_rd;
                     4'h4: begin r_wd = sum9[7:0]; vf_in = {7'd0, sum9[8]}; end
                     4'h5: begin r_wd = dxy[7:0]; vf_in = {7'd0, ~dxy[8]}; end
                     4'h6: begin r_wd = {1'b0, vx_ff[7:1]}; vf_in = {7'd0, vx_ff[0]}; end
                     4'h7: begin r_wd = dyx[7:0]; vf_in = {7'd0, ~dyx[8]}; end
                     4'hE: begin r_wd = {vx_ff[6:0], 1'b0}; vf_in = {7'd0, vx_ff[7]}; end
                     default: begin r_we = 1'b0; st_in = ST_UNKNOWN; end
                  endcase
                  if (r_we && (ns == 4'h4 || ns == 4'h5 || ns == 4'h6 || ns == 4'h7
                               || ns == 4'hE)) state_in = S_WB;
                  else if (r_we && xs == 4'hF) vf_in = r_wd;
               end
               4'hA: idx_in = {4'd0, nnn};
               4'hB: pc_in = nnn + {4'd0, r_rd};
               4'hC: begin
                  r_we = 1'b1; r_wd = rnd_ff & kk;
                  if (xs == 4'hF) vf_in = r_wd;
               end
               4'hD: ;
               4'hE: if (kk != 8'h9E && kk != 8'hA1) st_in = ST_UNKNOWN;
               default: begin
                  case (kk)
                     8'h07: begin r_we = 1'b1; r_wd = dly_ff; end
                     8'h0A: ;
                     8'h15: dly_in = vx_ff;
                     8'h18: snd_in = vx_ff;
                     8'h1E: idx_in = idx_ff + {8'd0, vx_ff};
                     8'h29: idx_in = {6'd0, vx_ff, 2'd0} + {8'd0, vx_ff};
                     8'h33: begin
                        bcd_in[0] = 8'd0; bcd_in[1] = 8'd0; bcd_in[2] = vx_ff;
                        cnt_in = 5'd0; state_in = S_BCD;
                     end
                     8'h55, 8'h65: begin
                        cnt_in = 5'd0; state_in = S_BLK;
                     end
                     default: st_in = ST_UNKNOWN;
                  endcase
                  if (r_we && xs == 4'hF) vf_in = r_wd;
               end
            endcase
         end
         S_WB: begin
            // flag is written after the result
            r_we = 1'b1; r_a = 4'hF; r_wd = vf_ff; state_in = S_OUT;
         end
         S_BCD: begin
            // one decimal digit step per cycle, then three writes
            if (cnt_ff < 5'd3) begin
               if (bcd_ff[2] >= 8'd100) begin
                  bcd_in[2] = bcd_ff[2] - 8'd100; bcd_in[0] = bcd_ff[0] + 8'd1;
               end else if (bcd_ff[2] >= 8'd10) begin
                  bcd_in[2] = bcd_ff[2] - 8'd10; bcd_in[1] = bcd_ff[1] + 8'd1;
               end else cnt_in = 5'd3;
            end else begin
               m_we = 1'b1; m_a = MAW'(bi - 16'd3); m_wd = bcd_ff[2'(cnt_ff - 5'd3)];
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd5) state_in = S_OUT;
            end
         end
         S_BLK: begin
            // issue read of V[cnt] or mem[I+cnt]
            r_a = cnt_ff[3:0]; m_a = bi[MAW-1:0]; state_in = S_BLKW;
         end
         S_BLKW: begin
            if (kk == 8'h55) begin
               m_we = 1'b1; m_a = bi[MAW-1:0]; m_wd = r_rd;
            end else begin
               r_we = 1'b1; r_a = cnt_ff[3:0]; r_wd = m_rd;
               if (cnt_ff[3:0] == 4'hF) vf_in = m_rd;
            end
            cnt_in = cnt_ff + 5'd1;
            state_in = (cnt_ff[3:0] == xs) ? S_OUT : S_BLK;
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; pc_ff <= 12'(START_ADDR); idx_ff <= '0; sp_ff <= '0;
         vf_ff <= '0; dly_ff <= '0; snd_ff <= '0; cnt_ff <= '0;
         st_ff <= ST_OK; clr_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pc_ff <= pc_in; idx_ff <= idx_in; sp_ff <= sp_in;
         vf_ff <= vf_in; dly_ff <= dly_in; snd_ff <= snd_in; cnt_ff <= cnt_in;
         st_ff <= st_in; clr_ff <= clr_in;
      end
      w_ff <= w_in; vx_ff <= vx_in; rnd_ff <= rnd_in; bcd_ff <= bcd_in;
   end
endmodule

/* test/tb_chip8_instruction_execute.sv */
// ----------------------------------------------------------------------------
// tb_chip8_instruction_execute
// Self-checking bench for the CHIP-8 execute unit. An initial block builds
// short programs that it loads beat by beat and then executes. While it does
// so it runs its own copy of the machine state and queues the expected
// response for every request beat. Clocked driver blocks apply random gaps
// and backpressure, and the monitor checks each response field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chip8_instruction_execute;
   import c8x_pkg::*;

   localparam int LIMIT_CYCLES = 600000;

   typedef struct {
      logic        op;
      logic [11:0] addr;
      logic [7:0]  data;
      logic [7:0]  rnd;
      bit          drain;
   } req_type;

   typedef struct {
      logic [11:0] pc;
      logic [15:0] idx;
      logic [1:0]  st;
      logic        clr;
      logic [7:0]  vf;
      logic [7:0]  dly;
      logic [7:0]  snd;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   chip8_instruction_execute i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // machine shadow
   logic [7:0]  sh_mem [4096];
   bit          sh_written [4096];
   logic [7:0]  sh_v [16];
   logic [15:0] sh_idx;
   logic [11:0] sh_pc;
   int          sh_sp;
   logic [11:0] sh_stack [16];
   logic [7:0]  sh_dly;
   logic [7:0]  sh_snd;

   req_type pending_q[$];
   rsp_type expected_q[$];

   int  errors = 0;
   int  beats_sent = 0;
   int  beats_seen = 0;
   int  n_exec = 0;
   int  n_overflow = 0;
   int  n_underflow = 0;
   int  n_unknown = 0;
   int  cycles = 0;
   bit  req_fire = 1'b0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   bit  drain_next = 1'b0;

   function automatic rsp_type snapshot(logic [1:0] st, logic clr);
      rsp_type r;
      r.pc  = sh_pc;
      r.idx = sh_idx;
      r.st  = st;
      r.clr = clr;
      r.vf  = sh_v[15];
      r.dly = sh_dly;
      r.snd = sh_snd;
      return r;
   endfunction

   function automatic void mem_store(logic [11:0] a, logic [7:0] d);
      sh_mem[a] = d;
      sh_written[a] = 1'b1;
   endfunction

   function automatic void queue_load(logic [11:0] a, logic [7:0] d);
      req_type q;
      q.op = OP_LOAD; q.addr = a; q.data = d; q.rnd = 8'($urandom_range(255));
      q.drain = drain_next;
      drain_next = 1'b0;
      pending_q.push_back(q);
      mem_store(a, d);
      expected_q.push_back(snapshot(ST_OK, 1'b0));
   endfunction

   // execute the word at pc in the shadow and return status and clear flag
   function automatic void exec_shadow(logic [7:0] rnd, output logic [1:0] st,
                                       output logic clr);
      logic [15:0] w;
      logic [3:0]  x, y, n;
      logic [7:0]  kk, vx, vy;
      logic [11:0] nnn;
      logic [8:0]  sum;
      w   = {sh_mem[sh_pc], sh_mem[sh_pc + 12'd1]};
      x   = w[11:8]; y = w[7:4]; n = w[3:0]; kk = w[7:0]; nnn = w[11:0];
      vx  = sh_v[x]; vy = sh_v[y];
      st  = ST_OK;
      clr = 1'b0;
      sh_pc = sh_pc + 12'd2;
      case (w[15:12])
         4'h0: begin
            if (w == W_CLS) clr = 1'b1;
            else if (w == W_RET) begin
               if (sh_sp == 0) st = ST_UNDERFLOW;
               else begin
                  sh_sp--;
                  sh_pc = sh_stack[sh_sp];
               end
            end else st = ST_UNKNOWN;
         end
         4'h1: sh_pc = nnn;
         4'h2: begin
            if (sh_sp >= STACK_DEPTH_DEF) st = ST_OVERFLOW;
            else begin
               sh_stack[sh_sp] = sh_pc;
               sh_sp++;
               sh_pc = nnn;
            end
         end
         4'h3: if (vx == kk) sh_pc = sh_pc + 12'd2;
         4'h4: if (vx != kk) sh_pc = sh_pc + 12'd2;
         4'h5, 4'h9: begin
            if (n != 4'h0) st = ST_UNKNOWN;
            else if ((vx == vy) == (w[15:12] == 4'h5)) sh_pc = sh_pc + 12'd2;
         end
         4'h6: sh_v[x] = kk;
         4'h7: sh_v[x] = vx + kk;
         4'h8: begin
            case (n)
               4'h0: sh_v[x] = vy;
               4'h1: sh_v[x] = vx | vy;
               4'h2: sh_v[x] = vx & vy;
               4'h3: sh_v[x] = vx ^ vy;
               // flag goes in last so it wins when x is VF
               4'h4: begin
                  sum = {1'b0, vx} + {1'b0, vy};
                  sh_v[x] = sum[7:0]; sh_v[15] = {7'd0, sum[8]};
               end
               4'h5: begin sh_v[x] = vx - vy; sh_v[15] = {7'd0, vx >= vy}; end
               4'h6: begin sh_v[x] = vx >> 1; sh_v[15] = {7'd0, vx[0]}; end
               4'h7: begin sh_v[x] = vy - vx; sh_v[15] = {7'd0, vy >= vx}; end
               4'hE: begin sh_v[x] = vx << 1; sh_v[15] = {7'd0, vx[7]}; end
               default: st = ST_UNKNOWN;
            endcase
         end
         4'hA: sh_idx = {4'd0, nnn};
         4'hB: sh_pc = nnn + {4'd0, sh_v[0]};
         4'hC: sh_v[x] = rnd & kk;
         4'hD: ;
         4'hE: if (kk != 8'h9E && kk != 8'hA1) st = ST_UNKNOWN;
         default: begin
            case (kk)
               8'h07: sh_v[x] = sh_dly;
               8'h0A: ;
               8'h15: sh_dly = vx;
               8'h18: sh_snd = vx;
               8'h1E: sh_idx = sh_idx + {8'd0, vx};
               8'h29: sh_idx = {8'd0, vx} * 16'd5;
               8'h33: begin
                  mem_store(sh_idx[11:0], vx / 8'd100);
                  mem_store(sh_idx[11:0] + 12'd1, (vx / 8'd10) % 8'd10);
                  mem_store(sh_idx[11:0] + 12'd2, vx % 8'd10);
               end
               8'h55: for (int i = 0; i <= x; i++)
                  mem_store(sh_idx[11:0] + i[11:0], sh_v[i]);
               8'h65: for (int i = 0; i <= x; i++)
                  sh_v[i] = sh_mem[sh_idx[11:0] + i[11:0]];
               default: st = ST_UNKNOWN;
            endcase
         end
      endcase
   endfunction

   function automatic logic [15:0] random_word(int calls, int rets);
      logic [15:0] w;
      logic [7:0]  fk [10] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33,
                               8'h55, 8'h65, 8'h33};
      logic [3:0]  an [10] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
                               4'hE, 4'h4};
      int k;
      w = 16'($urandom());
      if (calls > 0) return {4'h2, w[11:0]};
      if (rets > 0) return W_RET;
      k = $urandom_range(99);
      if (k < 4)       w = W_CLS;
      else if (k < 9)  w = W_RET;
      else if (k < 11) w[15:12] = 4'h0;
      else if (k < 18) w[15:12] = 4'h1;
      else if (k < 24) w[15:12] = 4'h2;
      else if (k < 38) w[15:12] = 4'h3 + 4'($urandom_range(1));
      else if (k < 46) begin
         w[15:12] = ($urandom_range(1) != 0) ? 4'h5 : 4'h9;
         if ($urandom_range(5) != 0) w[3:0] = 4'h0;
      end else if (k < 56) w[15:12] = 4'h6 + 4'($urandom_range(1));
      else if (k < 72) begin
         w[15:12] = 4'h8;
         if ($urandom_range(7) != 0) w[3:0] = an[$urandom_range(9)];
      end else if (k < 76) w[15:12] = 4'hA;
      else if (k < 79) w[15:12] = 4'hB;
      else if (k < 83) w[15:12] = 4'hC;
      else if (k < 85) w[15:12] = 4'hD;
      else if (k < 88) begin
         w[15:12] = 4'hE;
         if ($urandom_range(3) != 0) w[7:0] = ($urandom_range(1) != 0) ? 8'h9E : 8'hA1;
      end else begin
         w[15:12] = 4'hF;
         if ($urandom_range(7) != 0) w[7:0] = fk[$urandom_range(9)];
      end
      return w;
   endfunction

   // put the word at pc unless an already written word there is reused, then queue the execute beat
   function automatic void run_word(logic [15:0] w_new, bit may_reuse);
      logic [15:0] w;
      logic [1:0]  st;
      logic        clr;
      logic [11:0] a;
      bit          reuse;
      req_type     q;
      reuse = may_reuse && sh_written[sh_pc] && sh_written[sh_pc + 12'd1]
              && ($urandom_range(3) == 0);
      w = reuse ? {sh_mem[sh_pc], sh_mem[sh_pc + 12'd1]} : w_new;
      if (w[15:12] == 4'hF && w[7:0] == 8'h65) begin
         for (int i = 0; i <= w[11:8]; i++) begin
            a = sh_idx[11:0] + i[11:0];
            if (!sh_written[a]) queue_load(a, 8'($urandom_range(255)));
         end
      end
      if (!reuse) begin
         queue_load(sh_pc, w[15:8]);
         queue_load(sh_pc + 12'd1, w[7:0]);
      end
      q.op = OP_EXEC; q.addr = 12'($urandom_range(4095));
      q.data = 8'($urandom_range(255));
      q.rnd = 8'($urandom_range(255));
      q.drain = drain_next;
      drain_next = 1'b0;
      pending_q.push_back(q);
      exec_shadow(q.rnd, st, clr);
      n_exec++;
      if (st == ST_OVERFLOW) n_overflow++;
      if (st == ST_UNDERFLOW) n_underflow++;
      if (st == ST_UNKNOWN) n_unknown++;
      expected_q.push_back(snapshot(st, clr));
   endfunction

   // request driver
   always @(posedge clock) req_fire <= req_tvalid && req_tready;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         req_tvalid <= 1'b1;
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].drain && beats_seen != beats_sent)) begin
         req_tvalid <= 1'b0;
      end else begin
         req_type q;
         int      k;
         q = pending_q.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {3'd0, q.rnd, q.data, q.addr, q.op};
         beats_sent <= beats_sent + 1;
         k = $urandom_range(99);
         // quiet stretch (no gaps) for the first 60 of every 200 beats
         if ((beats_sent % 200) < 60) req_gap <= 0;
         else if (k < 65) req_gap <= 0;
         else if (k < 93) req_gap <= $urandom_range(3, 1);
         else req_gap <= $urandom_range(40, 8);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         int k;
         k = $urandom_range(99);
         rsp_tready <= 1'b1;
         if ((beats_seen % 200) >= 100) begin
            if (k < 20) rsp_stall <= $urandom_range(3, 1);
            else if (k < 25) rsp_stall <= $urandom_range(40, 8);
         end
      end
   end

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   // response monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen <= beats_seen + 1;
         if (expected_q.size() == 0) begin
            $error("response beat with nothing outstanding");
            errors++;
         end else begin
            rsp_type e;
            e = expected_q.pop_front();
            check_field("next_pc",      16'(e.pc),  16'(rsp_tdata[11:0]));
            check_field("index_value",  e.idx,      rsp_tdata[27:12]);
            check_field("status",       16'(e.st),  16'(rsp_tdata[29:28]));
            check_field("clear_screen", 16'(e.clr), 16'(rsp_tdata[30]));
            check_field("flag_value",   16'(e.vf),  16'(rsp_tdata[38:31]));
            check_field("delay_value",  16'(e.dly), 16'(rsp_tdata[46:39]));
            check_field("sound_value",  16'(e.snd), 16'(rsp_tdata[54:47]));
         end
      end
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [15:0] directed [] = '{16'h00E0, 16'h00EE, 16'h60FF, 16'h61FF,
         16'h8014, 16'h6FFE, 16'h8FF4, 16'h0123, 16'h5121, 16'h9120, 16'h8108,
         16'h1FFF, 16'hF033, 16'hFF55, 16'hFF65, 16'hD123, 16'hE09E, 16'hF00A,
         16'hC0FF, 16'hF115, 16'hF118, 16'hF207, 16'hF11E, 16'hF029, 16'hB123};
      int calls;
      int rets;
      for (int i = 0; i < 4096; i++) begin
         sh_mem[i] = 8'd0;
         sh_written[i] = 1'b0;
      end
      for (int i = 0; i < 16; i++) begin
         sh_v[i] = 8'd0;
         sh_stack[i] = 12'd0;
      end
      sh_idx = 16'd0; sh_pc = START_ADDR_DEF[11:0]; sh_sp = 0;
      sh_dly = 8'd0; sh_snd = 8'd0;

      foreach (directed[i]) run_word(directed[i], 1'b0);
      // noise loads reach every address and data bit
      queue_load(12'hFFF, 8'hFF);
      queue_load(12'h000, 8'h00);

      calls = 0; rets = 0;
      while (pending_q.size() < 650) begin
         if (pending_q.size() % 150 < 4) drain_next = 1'b1;
         if (calls == 0 && rets == 0 && $urandom_range(60) == 0) begin
            calls = $urandom_range(20, 15);
            rets = calls + $urandom_range(3);
         end
         if ($urandom_range(15) == 0) begin
            queue_load(12'($urandom_range(4095)), 8'($urandom_range(255)));
         end else begin
            run_word(random_word(calls, rets), 1'b1);
            if (calls > 0) calls--;
            else if (rets > 0) rets--;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && expected_q.size() == 0);
      repeat (100) @(posedge clock);
      $display("ran %0d beats, %0d instructions: %0d unknown, %0d overflow, %0d underflow",
               beats_sent, n_exec, n_unknown, n_overflow, n_underflow);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* chip8_instruction_execute.f */
rtl/c8x_pkg.sv
rtl/c8x_ram.sv
rtl/chip8_instruction_execute.sv
test/tb_chip8_instruction_execute.sv
